// ===== sv/wsa_pkg.sv =====
// wsa_pkg: shared constants for the wheel speed adaptive average block
// register map, reset values, field widths and window sizes
// no dependencies
package wsa_pkg;

  localparam int unsigned RING_DEPTH_DEF = 10;

  localparam int unsigned CIRC_W  = 12;
  localparam int unsigned MINI_W  = 10;
  localparam int unsigned T16_W   = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned WIN_W   = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SUM_W   = 20;
  localparam int unsigned DIV_W   = 22;
  localparam int unsigned DVS_W   = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  localparam logic [2:0] REG_CIRC   = 3'd0;
  localparam logic [2:0] REG_MIN    = 3'd1;
  localparam logic [2:0] REG_TOUT   = 3'd2;
  localparam logic [2:0] REG_PERIOD = 3'd3;
  localparam logic [2:0] REG_SLOW   = 3'd4;
  localparam logic [2:0] REG_MEDIUM = 3'd5;
  localparam logic [2:0] REG_FAST   = 3'd6;

  localparam logic [CIRC_W-1:0] CIRC_RST   = 12'd2100;
  localparam logic [MINI_W-1:0] MIN_RST    = 10'd50;
  localparam logic [T16_W-1:0]  TOUT_RST   = 16'd2500;
  localparam logic [T16_W-1:0]  PERIOD_RST = 16'd500;
  localparam logic [T16_W-1:0]  SLOW_RST   = 16'd2223;
  localparam logic [T16_W-1:0]  MEDIUM_RST = 16'd4167;
  localparam logic [T16_W-1:0]  FAST_RST   = 16'd6945;

  localparam logic [WIN_W-1:0] WIN_SLOW   = 4'd10;
  localparam logic [WIN_W-1:0] WIN_MEDIUM = 4'd7;
  localparam logic [WIN_W-1:0] WIN_FAST   = 4'd5;
  localparam logic [WIN_W-1:0] WIN_TOP    = 4'd3;

  localparam logic [9:0]         MM_PER_M  = 10'd1000;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 16'hFFFF;

endpackage

// ===== sv/wheel_speed_adaptive_average_top.sv =====
// wheel_speed_adaptive_average_top: reed switch wheel speed with adaptive averaging window
// interval ring, report sequencer and one shared restoring divider
// depends on wsa_pkg
//
// usage
//   input stream: one beat per millisecond tick, tdata[0] is the sampled switch level
//   (0 = closed). a falling level marks a wheel edge; edge intervals above the minimum
//   go into a ring of RING_DEPTH entries.
//   output stream: one beat every report period with speed, window and sample count;
//   tuser flags a speed forced to zero by the edge timeout.
//   configuration: apb port, seven 32 bit registers at byte addresses 0 to 24.
// sequence
//   a tick without a report only passes the edge state. a report tick picks the window w
//   (3, 5, 7 or 10); with w intervals held it reads the ring one entry per cycle for the
//   sum, then runs 22 steps each of the same divider for the average and for the speed.
//   s_axis_tready is high only while the sequencer is idle.
// reset and stalls
//   reset loads the register defaults and clears the ring count, pointers and timers.
//   the result sits in an output register; the next tick is taken while it waits, and
//   the sequencer holds in its last state only if a new result is ready before that
//   beat has been taken.
module wheel_speed_adaptive_average_top #(
  parameter int unsigned RING_DEPTH = wsa_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // slave stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // switch_level
  // master stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [23:0]                 m_axis_tdata_o,  // speed_mm_s, window_used, samples_held
  output logic                        m_axis_tuser_o,  // timed_out
  // apb configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wsa_pkg::ADDR_W-1:0]  paddr,
  input  logic [wsa_pkg::DATA_W-1:0]  pwdata,
  output logic [wsa_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import wsa_pkg::*;

  localparam int unsigned PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned STEP_W = $clog2(DIV_W);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EDGE  = 4'd1;
  localparam logic [3:0] ST_PICK  = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_DIVA  = 4'd4;
  localparam logic [3:0] ST_LOADB = 4'd5;
  localparam logic [3:0] ST_DIVB  = 4'd6;
  localparam logic [3:0] ST_SAT   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(RING_DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // configuration registers
  logic [CIRC_W-1:0] circ_q;
  logic [MINI_W-1:0] mini_q;
  logic [T16_W-1:0]  tout_lim_q, period_q, slow_q, medium_q, fast_q;
  logic              cfg_we;
  logic [2:0]        cfg_idx;

  // control state
  logic [3:0]         state_q, state_d;
  logic [TIME_W-1:0]  tick_q, last_edge_q;
  logic               edge_seen_q, prev_q, level_q;
  logic [PW-1:0]      wr_ptr_q, rd_idx_q, rd_addr;
  logic [CW-1:0]      stored_q;
  logic [WIN_W-1:0]   win_q, cnt_q, win_pick;
  logic [SPEED_W-1:0] last_speed_q, speed_q;
  logic [T16_W-1:0]   rcnt_q;
  logic               tout_q;
  logic               out_valid_q;

  // datapath
  logic [T16_W-1:0]   ring_q [RING_DEPTH];
  logic [T16_W-1:0]   rd_q;
  logic [SUM_W-1:0]   sum_q, sum_nx;
  logic [DIV_W-1:0]   quo_q, quo_nx;
  logic [DVS_W-1:0]   rem_q, rem_nx, dvs_q;
  logic [STEP_W-1:0]  step_q;
  logic [DVS_W:0]     rem_sh;
  logic [DVS_W+1:0]   diff;
  logic               ge;

  // output register
  logic [SPEED_W-1:0] out_speed_q;
  logic [WIN_W-1:0]   out_win_q, out_samp_q;
  logic               out_tout_q;

  // edge handling terms
  logic [TIME_W-1:0]  gap32, age32;
  logic [T16_W-1:0]   gap16;
  logic               falling, ring_we;
  logic [T16_W:0]     rcnt_nx;
  logic               out_free;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite & pready;

  always_comb begin
    unique case (cfg_idx)
      REG_CIRC:   prdata = DATA_W'(circ_q);
      REG_MIN:    prdata = DATA_W'(mini_q);
      REG_TOUT:   prdata = DATA_W'(tout_lim_q);
      REG_PERIOD: prdata = DATA_W'(period_q);
      REG_SLOW:   prdata = DATA_W'(slow_q);
      REG_MEDIUM: prdata = DATA_W'(medium_q);
      REG_FAST:   prdata = DATA_W'(fast_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q     <= CIRC_RST;
      mini_q     <= MIN_RST;
      tout_lim_q <= TOUT_RST;
      period_q   <= PERIOD_RST;
      slow_q     <= SLOW_RST;
      medium_q   <= MEDIUM_RST;
      fast_q     <= FAST_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_CIRC:   circ_q     <= pwdata[CIRC_W-1:0];
        REG_MIN:    mini_q     <= pwdata[MINI_W-1:0];
        REG_TOUT:   tout_lim_q <= pwdata[T16_W-1:0];
        REG_PERIOD: period_q   <= pwdata[T16_W-1:0];
        REG_SLOW:   slow_q     <= pwdata[T16_W-1:0];
        REG_MEDIUM: medium_q   <= pwdata[T16_W-1:0];
        REG_FAST:   fast_q     <= pwdata[T16_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_samp_q, out_win_q, out_speed_q};
  assign m_axis_tuser_o  = out_tout_q;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign falling = !level_q && prev_q;
  assign gap32   = tick_q - last_edge_q;
  assign gap16   = (|gap32[TIME_W-1:T16_W]) ? SPEED_MAX : gap32[T16_W-1:0];
  assign ring_we = (state_q == ST_EDGE) && falling && edge_seen_q &&
                   (gap16 > T16_W'(mini_q));
  assign rcnt_nx = {1'b0, rcnt_q} + 1'b1;
  assign age32   = tick_q - last_edge_q;

  always_comb begin
    if (last_speed_q < slow_q) begin
      win_pick = WIN_SLOW;
    end else if (last_speed_q < medium_q) begin
      win_pick = WIN_MEDIUM;
    end else if (last_speed_q < fast_q) begin
      win_pick = WIN_FAST;
    end else begin
      win_pick = WIN_TOP;
    end
  end

  assign rd_addr = (state_q == ST_PICK) ? ptr_dec(wr_ptr_q) : rd_idx_q;
  assign sum_nx  = sum_q + SUM_W'(rd_q);

  // shared restoring divider step
  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign ge     = !diff[DVS_W+1];
  assign rem_nx = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  assign quo_nx = {quo_q[DIV_W-2:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (s_axis_tvalid_i) state_d = ST_EDGE;
      ST_EDGE:  state_d = (rcnt_nx < {1'b0, period_q}) ? ST_IDLE : ST_PICK;
      ST_PICK:  state_d = ({1'b0, stored_q} >= (CW+1)'(win_pick)) ? ST_SUM : ST_DONE;
      ST_SUM:   if (cnt_q == win_q - 1'b1) state_d = ST_DIVA;
      ST_DIVA:  if (step_q == STEP_W'(DIV_W - 1)) state_d = ST_LOADB;
      ST_LOADB: state_d = (quo_q == '0) ? ST_DONE : ST_DIVB;
      ST_DIVB:  if (step_q == STEP_W'(DIV_W - 1)) state_d = ST_SAT;
      ST_SAT:   state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_q       <= '0;
      last_edge_q  <= '0;
      edge_seen_q  <= 1'b0;
      prev_q       <= 1'b1;
      level_q      <= 1'b1;
      wr_ptr_q     <= '0;
      rd_idx_q     <= '0;
      stored_q     <= '0;
      win_q        <= WIN_FAST;
      cnt_q        <= '0;
      last_speed_q <= '0;
      speed_q      <= '0;
      rcnt_q       <= '0;
      tout_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      step_q       <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            tick_q  <= tick_q + 1'b1;
            level_q <= s_axis_tdata_i[0];
          end
        end
        ST_EDGE: begin
          if (ring_we) begin
            wr_ptr_q <= ptr_inc(wr_ptr_q);
            if (stored_q != CW'(RING_DEPTH)) stored_q <= stored_q + 1'b1;
          end
          if (falling) begin
            last_edge_q <= tick_q;
            edge_seen_q <= 1'b1;
          end
          prev_q <= level_q;
          rcnt_q <= (rcnt_nx < {1'b0, period_q}) ? rcnt_nx[T16_W-1:0] : '0;
        end
        ST_PICK: begin
          win_q    <= win_pick;
          cnt_q    <= '0;
          speed_q  <= '0;
          rd_idx_q <= ptr_dec(rd_addr);
          tout_q   <= edge_seen_q && (age32 > TIME_W'(tout_lim_q));
        end
        ST_SUM: begin
          cnt_q    <= cnt_q + 1'b1;
          rd_idx_q <= ptr_dec(rd_addr);
          step_q   <= '0;
        end
        ST_DIVA, ST_DIVB: begin
          step_q <= step_q + 1'b1;
        end
        ST_LOADB: begin
          step_q <= '0;
        end
        ST_SAT: begin
          speed_q <= (|quo_q[DIV_W-1:SPEED_W]) ? SPEED_MAX : quo_q[SPEED_W-1:0];
        end
        ST_DONE: begin
          if (out_free) begin
            last_speed_q <= tout_q ? '0 : speed_q;
          end
        end
        default: ;
      endcase
    end
  end

  // ring and datapath registers
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wr_ptr_q] <= gap16;
    end
    rd_q <= ring_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_PICK: begin
        sum_q <= '0;
      end
      ST_SUM: begin
        sum_q <= sum_nx;
        quo_q <= DIV_W'(sum_nx);
        rem_q <= '0;
        dvs_q <= DVS_W'(win_q);
      end
      ST_DIVA, ST_DIVB: begin
        quo_q <= quo_nx;
        rem_q <= rem_nx;
      end
      ST_LOADB: begin
        dvs_q <= quo_q[DVS_W-1:0];
        quo_q <= DIV_W'(circ_q) * DIV_W'(MM_PER_M);
        rem_q <= '0;
      end
      ST_DONE: begin
        if (out_free) begin
          out_speed_q <= tout_q ? '0 : speed_q;
          out_win_q   <= win_q;
          out_samp_q  <= WIN_W'(stored_q);
          out_tout_q  <= tout_q;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVA || state_q == ST_DIVB) |-> (dvs_q != '0))
    else $error("divider running with zero divisor");

  a_stored_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stored_q <= CW'(RING_DEPTH)) && (wr_ptr_q < PW'(RING_DEPTH)))
    else $error("ring count or pointer out of range");

  a_sum_enough : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> ({1'b0, stored_q} >= (CW+1)'(win_q)))
    else $error("summing more intervals than stored");

  a_win_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (win_q == WIN_SLOW || win_q == WIN_MEDIUM ||
                             win_q == WIN_FAST || win_q == WIN_TOP))
    else $error("illegal averaging window");

  a_accept_edge : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == ST_EDGE))
    else $error("accepted tick not handled");

endmodule

// ===== tb/wsa_speed_checker.sv =====
`timescale 1ns / 100ps
// wsa_speed_checker: watches the tick, report and apb channels, keeps its own copy of the
// interval ring and settings, predicts each speed report and compares it field by field
// depends on wsa_pkg
module wsa_speed_checker #(
  parameter int unsigned RING_DEPTH = wsa_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [7:0]                  s_tdata_i,   // switch_level
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [23:0]                 m_tdata_i,   // speed_mm_s, window_used, samples_held
  input  logic                        m_tuser_i,   // timed_out
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic                        pready_i,
  input  logic [wsa_pkg::ADDR_W-1:0]  paddr_i,
  input  logic [wsa_pkg::DATA_W-1:0]  pwdata_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import wsa_pkg::*;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [WIN_W-1:0]   window;
    logic [WIN_W-1:0]   samples;
    logic               timed_out;
  } speed_report_t;

  speed_report_t reports_due[$];
  int fails;

  logic [CIRC_W-1:0] cfg_circ;
  logic [MINI_W-1:0] cfg_min;
  logic [T16_W-1:0]  cfg_tout;
  logic [T16_W-1:0]  cfg_period;
  logic [T16_W-1:0]  cfg_slow;
  logic [T16_W-1:0]  cfg_medium;
  logic [T16_W-1:0]  cfg_fast;

  logic [TIME_W-1:0]  ticks_now;
  logic [TIME_W-1:0]  edge_stamp;
  logic               have_edge;
  logic               level_prev;
  logic [15:0]        gap_ring [RING_DEPTH];
  int unsigned        ring_wr;
  logic [WIN_W-1:0]   ring_fill;
  logic [WIN_W-1:0]   win_len;
  logic [SPEED_W-1:0] speed_prev;
  logic [T16_W-1:0]   period_count;

  task automatic predict_tick(input logic level);
    logic [TIME_W-1:0] span;
    logic [16:0]       next_cnt;
    int unsigned       total;
    int unsigned       mean;
    int unsigned       quot;
    int unsigned       idx;
    speed_report_t     rep;
    ticks_now = ticks_now + 1;
    // falling level is a wheel edge
    if (!level && level_prev) begin
      if (have_edge) begin
        span = ticks_now - edge_stamp;
        if (span > 32'd65535) span = 32'd65535;
        if (span > {22'd0, cfg_min}) begin
          gap_ring[ring_wr] = span[15:0];
          ring_wr = (ring_wr == RING_DEPTH - 1) ? 0 : ring_wr + 1;
          if (ring_fill < RING_DEPTH) ring_fill = ring_fill + 1;
        end
      end
      edge_stamp = ticks_now;
      have_edge  = 1'b1;
    end
    level_prev = level;

    next_cnt = {1'b0, period_count} + 17'd1;
    if (next_cnt < {1'b0, cfg_period}) begin
      period_count = next_cnt[15:0];
    end else begin
      period_count = '0;
      if (speed_prev < cfg_slow) win_len = WIN_SLOW;
      else if (speed_prev < cfg_medium) win_len = WIN_MEDIUM;
      else if (speed_prev < cfg_fast) win_len = WIN_FAST;
      else win_len = WIN_TOP;
      rep = '0;
      if (ring_fill >= win_len) begin
        total = 0;
        for (int unsigned i = 0; i < win_len; i++) begin
          idx = (ring_wr + RING_DEPTH - 1 - i) % RING_DEPTH;
          total += gap_ring[idx];
        end
        mean = total / win_len;
        if (mean > 0) begin
          quot = (int'(cfg_circ) * 1000) / mean;
          rep.speed = (quot > 65535) ? SPEED_MAX : quot[15:0];
        end
      end
      if (have_edge && ((ticks_now - edge_stamp) > {16'd0, cfg_tout})) begin
        rep.speed     = '0;
        rep.timed_out = 1'b1;
      end
      rep.window  = win_len;
      rep.samples = ring_fill;
      speed_prev  = rep.speed;
      reports_due.push_back(rep);
    end
  endtask

  task automatic check_report(input logic [23:0] data, input logic flag);
    speed_report_t want;
    if (reports_due.size() == 0) begin
      $error("report beat with none expected: tdata %h tuser %b", data, flag);
      fails++;
    end else begin
      want = reports_due.pop_front();
      if (data[15:0] != want.speed) begin
        $error("speed_mm_s expected %0d got %0d", want.speed, data[15:0]);
        fails++;
      end
      if (data[19:16] != want.window) begin
        $error("window_used expected %0d got %0d", want.window, data[19:16]);
        fails++;
      end
      if (data[23:20] != want.samples) begin
        $error("samples_held expected %0d got %0d", want.samples, data[23:20]);
        fails++;
      end
      if (flag != want.timed_out) begin
        $error("timed_out expected %0d got %0d", want.timed_out, flag);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_circ     = CIRC_RST;
      cfg_min      = MIN_RST;
      cfg_tout     = TOUT_RST;
      cfg_period   = PERIOD_RST;
      cfg_slow     = SLOW_RST;
      cfg_medium   = MEDIUM_RST;
      cfg_fast     = FAST_RST;
      ticks_now    = '0;
      edge_stamp   = '0;
      have_edge    = 1'b0;
      level_prev   = 1'b1;
      ring_wr      = 0;
      ring_fill    = '0;
      win_len      = WIN_FAST;
      speed_prev   = '0;
      period_count = '0;
      reports_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          REG_CIRC:   cfg_circ   = pwdata_i[CIRC_W-1:0];
          REG_MIN:    cfg_min    = pwdata_i[MINI_W-1:0];
          REG_TOUT:   cfg_tout   = pwdata_i[T16_W-1:0];
          REG_PERIOD: cfg_period = pwdata_i[T16_W-1:0];
          REG_SLOW:   cfg_slow   = pwdata_i[T16_W-1:0];
          REG_MEDIUM: cfg_medium = pwdata_i[T16_W-1:0];
          REG_FAST:   cfg_fast   = pwdata_i[T16_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) predict_tick(s_tdata_i[0]);
      if (m_tvalid_i && m_tready_i) check_report(m_tdata_i, m_tuser_i);
      fail_count_o <= fails;
      pending_o    <= reports_due.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// testbench: drives millisecond ticks and apb settings into wheel_speed_adaptive_average_top,
// takes speed report beats with random stalls and gives the verdict
// depends on wsa_pkg, wheel_speed_adaptive_average_top and wsa_speed_checker
module testbench;
  import wsa_pkg::*;

  localparam logic [2:0] REG_SPARE     = 3'd7;
  localparam int         RANDOM_TICKS  = 1200;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         HOLD_CYCLES   = 400;

  logic              clk_i;
  logic              rst_ni;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // switch_level
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;   // speed_mm_s, window_used, samples_held
  logic              m_tuser;   // timed_out
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending;
  int random_ticks;
  bit calm;
  bit hold_req;

  wheel_speed_adaptive_average_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  wsa_speed_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[wheel_speed_adaptive_average_top] ERROR");
    $finish;
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
    logic [31:0] junk;
    junk = $urandom;
    return ($urandom_range(0, 1) != 0) ? (value | (junk << width)) : value;
  endfunction

  task automatic load_settings(input logic [31:0] circ, input logic [31:0] min_gap,
                               input logic [31:0] tout, input logic [31:0] period,
                               input logic [31:0] slow, input logic [31:0] mid_lim,
                               input logic [31:0] fast);
    apb_write(REG_CIRC, circ);
    apb_write(REG_MIN, min_gap);
    apb_write(REG_TOUT, tout);
    apb_write(REG_PERIOD, period);
    apb_write(REG_SLOW, slow);
    apb_write(REG_MEDIUM, mid_lim);
    apb_write(REG_FAST, fast);
  endtask

  task automatic send_tick(input logic level);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, level};
    do @(posedge clk_i); while (!s_tready);
  endtask

  // lowest bit goes first
  task automatic send_levels(input logic [31:0] levels, input int count);
    for (int i = 0; i < count; i++) send_tick(levels[i]);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_phase();
    logic [31:0] circ, min_gap, tout, period;
    int len, rot, low_w, pos, pause;
    bit noisy;
    logic level;
    case ($urandom_range(0, 5))
      0:       circ = 1;
      1:       circ = 4095;
      default: circ = $urandom_range(1, 4095);
    endcase
    case ($urandom_range(0, 7))
      6:       min_gap = 1023;
      7:       min_gap = $urandom_range(0, 1023);
      default: min_gap = $urandom_range(0, 6);
    endcase
    case ($urandom_range(0, 7))
      0:       tout = 1;
      1:       tout = 65535;
      2:       tout = 0;
      default: tout = $urandom_range(2, 150);
    endcase
    case ($urandom_range(0, 9))
      0:       period = 0;
      1:       period = 65535;
      2:       period = 1;
      default: period = $urandom_range(1, 30);
    endcase
    load_settings(with_junk(circ, CIRC_W), with_junk(min_gap, MINI_W),
                  with_junk(tout, T16_W), with_junk(period, T16_W),
                  with_junk(pick_limit(), T16_W), with_junk(pick_limit(), T16_W),
                  with_junk(pick_limit(), T16_W));
    calm  = ($urandom_range(0, 3) == 0);
    noisy = ($urandom_range(0, 4) == 0);
    len   = $urandom_range(40, 160);
    rot   = $urandom_range(2, 40);
    low_w = $urandom_range(1, (rot > 4) ? 3 : rot - 1);
    pos   = 0;
    pause = 0;
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        level = $urandom_range(0, 1);
      end else if (pause > 0) begin
        level = 1'b1;
        pause--;
      end else begin
        level = (pos < low_w) ? 1'b0 : 1'b1;
        pos++;
        if (pos >= rot) begin
          pos = 0;
          if ($urandom_range(0, 9) == 0) pause = $urandom_range(10, 200);
          rot = rot + $urandom_range(0, 4) - 2;
          if (rot < 2) rot = 2;
          if (rot > 40) rot = 40;
          if (low_w >= rot) low_w = rot - 1;
        end
      end
      send_tick(level);
    end
    random_ticks += len;
    settle();
  endtask

  // receiver side
  initial begin
    int stall;
    m_tready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
    end
  end

  initial begin
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    random_ticks = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first edge, held low level, short intervals, saturated speed, window of three
    load_settings(4095, 0, 65535, 1, 0, 0, 0);
    send_levels(32'b1000_1010_1010_00, 12);
    settle();
    // unmapped register, report on every tick, single tick timeout
    apb_write(REG_SPARE, 32'h0000_0005);
    apb_write(REG_PERIOD, 0);
    apb_write(REG_TOUT, 1);
    send_levels(32'b101, 3);
    settle();
    // period lowered below the running count
    apb_write(REG_PERIOD, 65535);
    send_levels(32'b111111, 6);
    settle();
    apb_write(REG_PERIOD, 2);
    send_levels(32'b0, 1);
    settle();

    while (random_ticks < RANDOM_TICKS) random_phase();

    // receiver holds off while ticks keep coming
    load_settings(2100, 0, 65535, 1, 2223, 4167, 6945);
    calm = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 80; i++) send_tick((i % 4) != 0);
    settle();

    apb_write(REG_PERIOD, 1);
    send_levels(32'b101010, 6);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("[wheel_speed_adaptive_average_top] OK");
    end else begin
      $display("[wheel_speed_adaptive_average_top] ERROR");
    end
    $finish;
  end

endmodule
